### rtl/cbc_pkg.sv
// Shared types, constants and mapper decode table for the cartridge bank controller.
package cbc_pkg;

   // Number of ROM bank bits that the bank register really keeps.
   localparam int ROM_BANK_BITS = 9;

   // Field widths.
   localparam int ADDR_W     = 15;
   localparam int DATA_W     = 8;
   localparam int ROM_W      = 9;
   localparam int RAM_W      = 4;
   localparam int TYPE_W     = 5;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Mask that limits a ROM bank number to ROM_BANK_BITS bits.
   localparam logic [ROM_W-1:0] ROM_BITS_MASK = ROM_W'((1 << ROM_BANK_BITS) - 1);

   // Reset values of the configuration and bank registers.
   localparam logic [TYPE_W-1:0] TYPE_RESET     = '0;
   localparam logic [ROM_W-1:0]  ROM_MASK_RESET = ROM_W'(1);
   localparam logic [RAM_W-1:0]  RAM_MASK_RESET = '0;
   localparam logic [ROM_W-1:0]  ROM_BANK_RESET = ROM_W'(1);
   localparam logic [RAM_W-1:0]  RAM_BANK_RESET = '0;

   // Configuration register indexes.
   localparam logic [1:0] REG_CART_TYPE = 2'd0;
   localparam logic [1:0] REG_ROM_MASK  = 2'd1;
   localparam logic [1:0] REG_RAM_MASK  = 2'd2;

   // Mapper kinds.
   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_MBC1  = 3'd1,
      KIND_MBC2  = 3'd2,
      KIND_MBC3  = 3'd3,
      KIND_MMM01 = 3'd4,
      KIND_MBC5  = 3'd5
   } kind_type;

   // Configuration as seen by the bank logic.
   typedef struct packed {
      logic [TYPE_W-1:0] cart_type_code;
      logic [ROM_W-1:0]  rom_bank_mask;
      logic [RAM_W-1:0]  ram_bank_mask;
   } cfg_type;

   // Map the cartridge type byte onto a mapper kind.
   function automatic kind_type kind_of(input logic [TYPE_W-1:0] code);
      kind_type k;
      case (code)
         5'h01, 5'h02, 5'h03:                      k = KIND_MBC1;
         5'h05, 5'h06:                             k = KIND_MBC2;
         5'h0B, 5'h0C, 5'h0D:                      k = KIND_MMM01;
         5'h0F, 5'h10, 5'h11, 5'h12, 5'h13:        k = KIND_MBC3;
         5'h19, 5'h1A, 5'h1B, 5'h1C, 5'h1D, 5'h1E: k = KIND_MBC5;
         default:                                  k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

### rtl/cbc_csr.sv
// Configuration register file behind the APB-style port.
module cbc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cbc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cbc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cbc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output cbc_pkg::cfg_type              cfg
);
   import cbc_pkg::*;

   logic [TYPE_W-1:0] type_ff;
   logic [ROM_W-1:0]  rom_mask_ff;
   logic [RAM_W-1:0]  ram_mask_ff;
   logic              wr_en;
   logic [1:0]        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3:2];

   // Register writes on the access cycle of a write transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff     <= TYPE_RESET;
         rom_mask_ff <= ROM_MASK_RESET;
         ram_mask_ff <= RAM_MASK_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_CART_TYPE: type_ff     <= csr_pwdata[TYPE_W-1:0];
            REG_ROM_MASK:  rom_mask_ff <= csr_pwdata[ROM_W-1:0];
            REG_RAM_MASK:  ram_mask_ff <= csr_pwdata[RAM_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (reg_sel)
         REG_CART_TYPE: csr_prdata = CSR_DATA_W'(type_ff);
         REG_ROM_MASK:  csr_prdata = CSR_DATA_W'(rom_mask_ff);
         REG_RAM_MASK:  csr_prdata = CSR_DATA_W'(ram_mask_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.cart_type_code = type_ff;
   assign cfg.rom_bank_mask  = rom_mask_ff;
   assign cfg.ram_bank_mask  = ram_mask_ff;

endmodule

### rtl/cbc_bank_logic.sv
// Mapper decode and next bank register values for one cartridge write.
module cbc_bank_logic (
   input  cbc_pkg::cfg_type             cfg,
   input  logic [cbc_pkg::ADDR_W-1:0]   write_address,
   input  logic [cbc_pkg::DATA_W-1:0]   write_data,
   input  logic [cbc_pkg::ROM_W-1:0]    rom_bank_cur,
   input  logic [cbc_pkg::RAM_W-1:0]    ram_bank_cur,
   output logic [cbc_pkg::ROM_W-1:0]    rom_bank_next,
   output logic [cbc_pkg::RAM_W-1:0]    ram_bank_next,
   output logic                         unsupported
);
   import cbc_pkg::*;

   kind_type          kind;
   logic [ROM_W-1:0]  rom_raw;
   logic              rom_wr;
   logic              ram_wr;
   logic [ROM_W-1:0]  nz5;
   logic [ROM_W-1:0]  nz4;
   logic [ROM_W-1:0]  nz7;
   logic [ROM_W-1:0]  rom_lim;
   logic [RAM_W-1:0]  ram_lim;

   assign kind = kind_of(cfg.cart_type_code);

   // Bank numbers with the zero-to-one rule applied.
   assign nz5 = (write_data[4:0] == '0) ? ROM_W'(1) : ROM_W'(write_data[4:0]);
   assign nz4 = (write_data[3:0] == '0) ? ROM_W'(1) : ROM_W'(write_data[3:0]);
   assign nz7 = (write_data[6:0] == '0) ? ROM_W'(1) : ROM_W'(write_data[6:0]);

   // Decode which bank register the write hits and its raw new value.
   always_comb begin
      rom_raw     = rom_bank_cur;
      rom_wr      = 1'b0;
      ram_wr      = 1'b0;
      unsupported = 1'b0;
      case (kind)
         KIND_MBC1: begin
            if (write_address[14:13] == 2'd1) begin
               rom_wr  = 1'b1;
               rom_raw = nz5;
            end
         end
         KIND_MBC2: begin
            if (!write_address[14] && write_address[8]) begin
               rom_wr  = 1'b1;
               rom_raw = nz4;
            end
         end
         KIND_MBC3: begin
            if (write_address[14:13] == 2'd1) begin
               rom_wr  = 1'b1;
               rom_raw = nz7;
            end else if (write_address[14:13] == 2'd2) begin
               ram_wr = 1'b1;
            end
         end
         KIND_MBC5: begin
            case (write_address[14:12])
               3'd2: begin
                  rom_wr  = 1'b1;
                  rom_raw = {rom_bank_cur[8], write_data};
               end
               3'd3: begin
                  rom_wr  = 1'b1;
                  rom_raw = {write_data[0], rom_bank_cur[7:0]};
               end
               3'd4, 3'd5: ram_wr = 1'b1;
               default: ;
            endcase
         end
         KIND_MMM01: unsupported = 1'b1;
         default: ;
      endcase
   end

   // Limit by the configured bank-count masks.
   assign rom_lim = rom_raw & cfg.rom_bank_mask & ROM_BITS_MASK;
   assign ram_lim = write_data[RAM_W-1:0] & cfg.ram_bank_mask;

   assign rom_bank_next = rom_wr ? rom_lim : rom_bank_cur;
   assign ram_bank_next = ram_wr ? ram_lim : ram_bank_cur;

endmodule

### rtl/cartridge_bank_controller_unit.sv
// Top level of the cartridge bank controller: input stage, bank state and result stage.
//
// Usage: each transaction on the req_ channel is one processor write into the
// 32 KiB cartridge ROM window (address and data byte). For every write the
// block returns one transaction on the rsp_ channel holding the ROM bank and
// RAM bank registers after that write, plus a flag in rsp_tuser that is set
// when the cartridge type selects the unsupported MMM01 mapper.
// The mapper kind and bank-count masks are set through the csr_ port; the user
// must set them only while no write is in flight, as the block does not enforce it.
// Pipeline: a write accepted lands in the input register and moves on to the
// result register, which drives rsp_tvalid, once the result stage is free or drains.
// Throughput: one write per cycle, sustained while rsp_tready stays high;
// the bank registers are updated by a single pass of decode and
// mask logic as an item moves from the input register to the result register.
// Stalls: when rsp_tready is low the result holds, and one more write can
// still be taken into the input register; after that req_tready drops.
// Reset: synchronous, active high; ROM bank 1, RAM bank 0, type code 0,
// ROM mask 1, RAM mask 0, both channel stages empty.
module cartridge_bank_controller_unit (
   input  logic                           clock,
   input  logic                           reset,
   // write_address [14:0], write_data [22:15], zero padding [23]
   input  logic [cbc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // rom_bank [8:0], ram_bank [12:9], zero padding [15:13]
   output logic [cbc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // unsupported_mapper [0]
   output logic                           rsp_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cbc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cbc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cbc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                           csr_pready
);
   import cbc_pkg::*;

   cfg_type           cfg;
   logic              in_valid_ff;
   logic [ADDR_W-1:0] in_addr_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              out_valid_ff;
   logic              out_flag_ff;
   logic [ROM_W-1:0]  rom_bank_ff;
   logic [RAM_W-1:0]  ram_bank_ff;
   logic [ROM_W-1:0]  rom_bank_in;
   logic [RAM_W-1:0]  ram_bank_in;
   logic              flag_in;
   logic              advance;
   logic              req_fire;

   cbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cbc_bank_logic u_bank (
      .cfg           (cfg),
      .write_address (in_addr_ff),
      .write_data    (in_data_ff),
      .rom_bank_cur  (rom_bank_ff),
      .ram_bank_cur  (ram_bank_ff),
      .rom_bank_next (rom_bank_in),
      .ram_bank_next (ram_bank_in),
      .unsupported   (flag_in)
   );

   // Handshake: the input stage moves on whenever the result stage is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_addr_ff <= req_tdata[ADDR_W-1:0];
         in_data_ff <= req_tdata[ADDR_W +: DATA_W];
      end
   end

   // Bank state doubles as the result payload register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff  <= ROM_BANK_RESET;
         ram_bank_ff  <= RAM_BANK_RESET;
         out_flag_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rom_bank_ff <= rom_bank_in;
            ram_bank_ff <= ram_bank_in;
            out_flag_ff <= flag_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {RSP_DATA_W'(0) | {3'b000, ram_bank_ff, rom_bank_ff}};
   assign rsp_tuser  = out_flag_ff;

`ifndef ASSERT_OFF
   // A full input stage that cannot move must be what blocks new writes.
   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("req_tready low without a stalled pipeline");

   // Every item that leaves the input stage shows up as a result.
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed write produced no result");

   // A write under the unsupported mapper leaves both banks unchanged.
   a_unsupported_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && flag_in) |=> (rom_bank_ff == $past(rom_bank_ff) &&
                                ram_bank_ff == $past(ram_bank_ff)))
      else $error("unsupported mapper changed a bank register");

   // Reset leaves the ROM bank at one and both stages empty.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (rom_bank_ff == ROM_BANK_RESET && !out_valid_ff && !in_valid_ff))
      else $error("bad state after reset");
`endif

endmodule

### bench/cbc_bank_checker.sv
// Checker for the cartridge bank controller: predicts bank registers and compares results.
module cbc_bank_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [cbc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [cbc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cbc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cbc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [cbc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input  logic                            csr_pready,
   output int                              error_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cbc_pkg::*;

   // Byte addresses of the configuration registers.
   localparam logic [CSR_ADDR_W-1:0] CSR_TYPE_ADDR     = {REG_CART_TYPE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] CSR_ROM_MASK_ADDR = {REG_ROM_MASK, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] CSR_RAM_MASK_ADDR = {REG_RAM_MASK, 2'b00};

   // Address windows, decoded from address bits 14:13 or, for MBC5, bits 14:12.
   localparam logic [1:0] AREA_ROM_BANK      = 2'd1;
   localparam logic [1:0] AREA_RAM_BANK      = 2'd2;
   localparam logic [2:0] MBC5_AREA_ROM_LOW  = 3'd2;
   localparam logic [2:0] MBC5_AREA_ROM_HIGH = 3'd3;
   localparam logic [2:0] MBC5_AREA_RAM_A    = 3'd4;
   localparam logic [2:0] MBC5_AREA_RAM_B    = 3'd5;

   localparam int MAX_PRINTED = 50;

   typedef struct packed {
      logic [ROM_W-1:0] rom;
      logic [RAM_W-1:0] ram;
      logic             unsupported;
   } bank_view_type;

   // Shadow copy of the configuration and of the bank registers.
   logic [TYPE_W-1:0] type_q;
   logic [ROM_W-1:0]  rom_mask_q;
   logic [RAM_W-1:0]  ram_mask_q;
   logic [ROM_W-1:0]  rom_bank_q;
   logic [RAM_W-1:0]  ram_bank_q;

   bank_view_type expected_banks[$];

   // Print one line for a mismatch, up to MAX_PRINTED of them, and count it.
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < MAX_PRINTED)
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                  want);
      error_count = error_count + 1;
   endtask

   // Mapper kind that a cartridge type code selects.
   function automatic kind_type mapper_for(input logic [TYPE_W-1:0] code);
      kind_type k;
      case (code)
         5'h01, 5'h02, 5'h03:                      k = KIND_MBC1;
         5'h05, 5'h06:                             k = KIND_MBC2;
         5'h0B, 5'h0C, 5'h0D:                      k = KIND_MMM01;
         5'h0F, 5'h10, 5'h11, 5'h12, 5'h13:        k = KIND_MBC3;
         5'h19, 5'h1A, 5'h1B, 5'h1C, 5'h1D, 5'h1E: k = KIND_MBC5;
         default:                                  k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [ROM_W-1:0] clip_rom(input logic [ROM_W-1:0] v);
      return v & rom_mask_q & ROM_BITS_MASK;
   endfunction

   // Bank zero is not selectable on the older mappers and reads as bank one.
   function automatic logic [ROM_W-1:0] skip_zero(input logic [ROM_W-1:0] v);
      return (v == '0) ? ROM_W'(1) : v;
   endfunction

   // Apply one processor write to the shadow banks and return the banks afterward.
   function automatic bank_view_type predict_bank_update(input logic [ADDR_W-1:0] addr,
                                                         input logic [DATA_W-1:0] data);
      bank_view_type view;
      view.unsupported = 1'b0;
      case (mapper_for(type_q))
         KIND_MBC1: begin
            if (addr[14:13] == AREA_ROM_BANK)
               rom_bank_q = clip_rom(skip_zero(ROM_W'(data[4:0])));
         end
         KIND_MBC2: begin
            if (!addr[14] && addr[8])
               rom_bank_q = clip_rom(skip_zero(ROM_W'(data[3:0])));
         end
         KIND_MBC3: begin
            if (addr[14:13] == AREA_ROM_BANK)
               rom_bank_q = clip_rom(skip_zero(ROM_W'(data[6:0])));
            else if (addr[14:13] == AREA_RAM_BANK)
               ram_bank_q = data[RAM_W-1:0] & ram_mask_q;
         end
         KIND_MBC5: begin
            case (addr[14:12])
               MBC5_AREA_ROM_LOW:  rom_bank_q = clip_rom({rom_bank_q[8], data});
               MBC5_AREA_ROM_HIGH: rom_bank_q = clip_rom({data[0], rom_bank_q[7:0]});
               MBC5_AREA_RAM_A, MBC5_AREA_RAM_B: ram_bank_q = data[RAM_W-1:0] & ram_mask_q;
               default: ;
            endcase
         end
         KIND_MMM01: view.unsupported = 1'b1;
         default: ;
      endcase
      view.rom = rom_bank_q;
      view.ram = ram_bank_q;
      return view;
   endfunction

   // Watch all three ports at each rising edge.
   always @(posedge clock) begin
      bank_view_type want;
      logic [CSR_DATA_W-1:0] reg_value;
      if (reset) begin
         type_q     = TYPE_RESET;
         rom_mask_q = ROM_MASK_RESET;
         ram_mask_q = RAM_MASK_RESET;
         rom_bank_q = ROM_BANK_RESET;
         ram_bank_q = RAM_BANK_RESET;
         expected_banks.delete();
      end else begin
         // Register writes and read-back checks.
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr)
                  CSR_TYPE_ADDR:     type_q     = csr_pwdata[TYPE_W-1:0];
                  CSR_ROM_MASK_ADDR: rom_mask_q = csr_pwdata[ROM_W-1:0];
                  CSR_RAM_MASK_ADDR: ram_mask_q = csr_pwdata[RAM_W-1:0];
                  default: ;
               endcase
            end else begin
               case (csr_paddr)
                  CSR_TYPE_ADDR:     reg_value = CSR_DATA_W'(type_q);
                  CSR_ROM_MASK_ADDR: reg_value = CSR_DATA_W'(rom_mask_q);
                  default:           reg_value = CSR_DATA_W'(ram_mask_q);
               endcase
               if (csr_prdata !== reg_value)
                  report_mismatch("register read", csr_prdata, reg_value);
            end
         end

         // Result transaction against the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_banks.size() == 0) begin
               report_mismatch("result with no write pending", rsp_tdata, 0);
            end else begin
               want = expected_banks.pop_front();
               if (rsp_tdata[ROM_W-1:0] !== want.rom)
                  report_mismatch("rom_bank", rsp_tdata[ROM_W-1:0], want.rom);
               if (rsp_tdata[ROM_W+RAM_W-1:ROM_W] !== want.ram)
                  report_mismatch("ram_bank", rsp_tdata[ROM_W+RAM_W-1:ROM_W], want.ram);
               if (rsp_tuser !== want.unsupported)
                  report_mismatch("unsupported_mapper", rsp_tuser, want.unsupported);
            end
         end

         // Write transaction: predict its result.
         if (req_tvalid && req_tready)
            expected_banks.push_back(predict_bank_update(req_tdata[ADDR_W-1:0],
                                                         req_tdata[ADDR_W+DATA_W-1:ADDR_W]));
      end
      pending_count <= expected_banks.size();
   end

endmodule

### bench/tb_top.sv
// Testbench top for the cartridge bank controller: clock, reset, stimulus and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cbc_pkg::*;

   localparam int  RANDOM_PHASES = 24;
   localparam int  PHASE_WRITES  = 60;
   localparam int  SETTLE_CYCLES = 4;
   localparam int  CYCLE_LIMIT   = 200000;

   localparam logic [CSR_ADDR_W-1:0] CSR_TYPE_ADDR     = {REG_CART_TYPE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] CSR_ROM_MASK_ADDR = {REG_ROM_MASK, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] CSR_RAM_MASK_ADDR = {REG_RAM_MASK, 2'b00};

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                   clock;
   logic                   reset;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int             error_count;
   int             pending_count;
   int             cycle_count = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   logic [2:0]     stall_phase = '0;

   cartridge_bank_controller_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cbc_bank_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Free-running 10 ns clock.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result-side back-pressure: modes of random length, including a no-stall mode.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 3'd1;
      case (stall_mode)
         STALL_NONE:  rsp_tready <= 1'b1;
         STALL_HALF:  rsp_tready <= ($urandom_range(0, 1) == 1);
         STALL_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:     rsp_tready <= (stall_phase[1:0] != 2'd3);
      endcase
   end

   // One APB access: setup phase, then access phase until pready, then back to idle.
   task automatic csr_access(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] value);
      logic ready_seen;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ready_seen = csr_pready;
         @(posedge clock);
      end while (!ready_seen);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every predicted result has arrived, then let the pipeline settle.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reprogram the mapper while idle; upper data bits carry noise that must be ignored.
   task automatic set_cartridge(input logic [TYPE_W-1:0] code, input logic [ROM_W-1:0] rom_mask,
                                input logic [RAM_W-1:0] ram_mask);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_access(1'b1, CSR_TYPE_ADDR, CSR_DATA_W'({$urandom(), code}));
      csr_access(1'b1, CSR_ROM_MASK_ADDR, CSR_DATA_W'({$urandom(), rom_mask}));
      csr_access(1'b1, CSR_RAM_MASK_ADDR, CSR_DATA_W'({$urandom(), ram_mask}));
      csr_access(1'b0, CSR_TYPE_ADDR, '0);
      csr_access(1'b0, CSR_ROM_MASK_ADDR, '0);
      csr_access(1'b0, CSR_RAM_MASK_ADDR, '0);
   endtask

   // Send one bus write, opening a new burst after a random gap when the last one ran out.
   task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      int  gap;
      logic ready_seen;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tdata  <= {1'b0, data, addr};
      req_tvalid <= 1'b1;
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      burst_left = burst_left - 1;
   endtask

   // Random type code, mostly one of the working mappers.
   function automatic logic [TYPE_W-1:0] pick_type_code();
      case ($urandom_range(0, 4))
         0:       return TYPE_W'($urandom_range(1, 3));
         1:       return TYPE_W'($urandom_range(5, 6));
         2:       return TYPE_W'($urandom_range(15, 19));
         3:       return TYPE_W'($urandom_range(25, 30));
         default: return TYPE_W'($urandom_range(0, 31));
      endcase
   endfunction

   // Random bank mask: zero, full, a power of two minus one, or anything.
   function automatic logic [ROM_W-1:0] pick_mask(input int bits);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return ROM_W'((1 << bits) - 1);
         2, 3:    return ROM_W'((1 << $urandom_range(1, bits)) - 1);
         default: return ROM_W'($urandom_range(0, (1 << bits) - 1));
      endcase
   endfunction

   // Random write: any of the eight 4 KiB windows, data leaning on zero and all-ones.
   task automatic send_random_write();
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      addr = {3'($urandom_range(0, 7)), 12'($urandom())};
      case ($urandom_range(0, 7))
         0:       data = '0;
         1:       data = '1;
         default: data = DATA_W'($urandom());
      endcase
      send_write(addr, data);
   endtask

   // Stimulus and verdict.
   initial begin
      reset       <= 1'b1;
      req_tdata   <= '0;
      req_tvalid  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values read back; no mapper, so the write changes nothing.
      csr_access(1'b0, CSR_TYPE_ADDR, '0);
      csr_access(1'b0, CSR_ROM_MASK_ADDR, '0);
      csr_access(1'b0, CSR_RAM_MASK_ADDR, '0);
      send_write(15'h2000, 8'h05);

      // MBC1: zero bank becomes one, five data bits, other windows ignored.
      set_cartridge(5'h01, 9'h1FF, 4'hF);
      send_write(15'h2000, 8'h00);
      send_write(15'h3FFF, 8'hFF);
      send_write(15'h0000, 8'h03);
      send_write(15'h7FFF, 8'h07);

      // MBC2: only writes below 0x4000 with address bit 8 set count.
      set_cartridge(5'h05, 9'h1FF, 4'hF);
      send_write(15'h0100, 8'h00);
      send_write(15'h3FFF, 8'hFE);
      send_write(15'h3EFF, 8'h03);
      send_write(15'h4100, 8'h03);

      // MBC3: seven-bit ROM bank and the RAM bank window.
      set_cartridge(5'h13, 9'h1FF, 4'hF);
      send_write(15'h2000, 8'hFF);
      send_write(15'h4000, 8'hFF);
      send_write(15'h6000, 8'h01);
      send_write(15'h3FFF, 8'h00);

      // MBC5: bank zero allowed, separate low byte and bit 8, RAM bank window.
      set_cartridge(5'h19, 9'h1FF, 4'hF);
      send_write(15'h2000, 8'h00);
      send_write(15'h3000, 8'h01);
      send_write(15'h2FFF, 8'hFF);
      send_write(15'h5FFF, 8'hFA);
      send_write(15'h7FFF, 8'h55);
      send_write(15'h1000, 8'h12);

      // Unsupported mapper raises the flag and changes nothing.
      set_cartridge(5'h0B, 9'h1FF, 4'hF);
      send_write(15'h2000, 8'h33);

      // Zero masks force bank zero even after the zero-to-one rule.
      set_cartridge(5'h01, 9'h000, 4'h0);
      send_write(15'h2000, 8'h00);

      // Highest type code is no mapper.
      set_cartridge(5'h1F, 9'h1FF, 4'hF);
      send_write(15'h2000, 8'h01);

      // Random phases, each with its own cartridge setup.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_cartridge(pick_type_code(), pick_mask(ROM_W), RAM_W'(pick_mask(RAM_W)));
         for (int n = 0; n < PHASE_WRITES; n++)
            send_random_write();
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
